// ===== design/tbm_pkg.sv =====
// tbm_pkg: shared types and fixed constants for the ternary bitmask matvec block.
// No dependencies.

package tbm_pkg;

   localparam int WORD_BITS   = 32;
   localparam int LANE_W      = 5;
   localparam int ACT_W       = 8;
   localparam int CFG_W       = 11;
   localparam int ACT_INDEX_W = 10;
   localparam int ROW_SUM_W   = 19;
   localparam int ROW_INDEX_W = 10;
   localparam int WSUM_W      = 14;

   localparam int SUM_MAX = 262143;
   localparam int SUM_MIN = -262144;

   localparam logic [CFG_W-1:0] COL_COUNT_RESET = 11'd1024;
   localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 11'd1024;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MASK = 1'b1
   } cmd_type;

   localparam logic CSR_COL_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   typedef struct packed {
      logic                   row_end;
      logic                   last_row;
      logic [ROW_INDEX_W-1:0] row_index;
   } tag_type;

endpackage

// ===== design/ternary_bitmask_matvec.sv =====
// ternary_bitmask_matvec: banked activation store, 32-lane ternary word sum, row accumulator.
// Depends on tbm_pkg.

// Takes one beat per cycle, load or mask alike, while req_stall is low. A load
// writes one of 32 activation banks (column mod 32 picks the bank). A mask beat
// reads all 32 banks at the current word of the row in the cycle it is accepted,
// into stage one; the adder tree sums the word into stage two, which adds it to
// the row accumulator or, on a row's last word, passes the saturated row sum to
// the output register. Two pipeline stages plus the output register keep taking
// beats while a result waits on rsp_stall, until another row end reaches stage two.
module ternary_bitmask_matvec #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [tbm_pkg::ACT_INDEX_W-1:0]      req_act_index,
   input  logic signed [tbm_pkg::ACT_W-1:0]     req_act_value,
   input  logic [tbm_pkg::WORD_BITS-1:0]        req_pos_word,
   input  logic [tbm_pkg::WORD_BITS-1:0]        req_neg_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tbm_pkg::ROW_SUM_W-1:0] rsp_row_sum,
   output logic [tbm_pkg::ROW_INDEX_W-1:0]      rsp_row_index,
   output logic                                 rsp_last_row,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [tbm_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int WORDS  = (MAX_COLS + tbm_pkg::WORD_BITS - 1) / tbm_pkg::WORD_BITS;
   localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW0    = $clog2(MAX_COLS + 1);
   localparam int CW     = ((CW0 > tbm_pkg::CFG_W) ? CW0 : tbm_pkg::CFG_W) + 1;
   localparam int XW     = (CW > tbm_pkg::ACT_INDEX_W) ? CW : tbm_pkg::ACT_INDEX_W;
   localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCW0   = $clog2(MAX_ROWS + 1);
   localparam int RCW    = ((RCW0 > tbm_pkg::CFG_W) ? RCW0 : tbm_pkg::CFG_W) + 1;
   localparam int RXW    = (RW > tbm_pkg::ROW_INDEX_W) ? RW : tbm_pkg::ROW_INDEX_W;
   localparam int ACC_W0 = $clog2(WORDS + 1) + tbm_pkg::WSUM_W + 1;
   localparam int ACC_W  = (ACC_W0 > tbm_pkg::ROW_SUM_W + 1) ? ACC_W0 : tbm_pkg::ROW_SUM_W + 1;

   localparam int NL = tbm_pkg::WORD_BITS;

   // configuration
   logic [tbm_pkg::CFG_W-1:0] col_count_ff, col_count_in;
   logic [tbm_pkg::CFG_W-1:0] row_count_ff, row_count_in;

   // sequencing state
   logic [AW-1:0] word_ff, word_in;
   logic [RW-1:0] row_ff, row_in;

   // pipeline
   logic                          s1_valid_ff, s1_valid_in;
   logic [NL-1:0]                 s1_pos_ff, s1_neg_ff;
   logic [tbm_pkg::ACT_W-1:0]     s1_act_ff [NL];
   tbm_pkg::tag_type              s1_tag_ff;
   logic                          s2_valid_ff, s2_valid_in;
   logic signed [tbm_pkg::WSUM_W-1:0] s2_wsum_ff;
   tbm_pkg::tag_type              s2_tag_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [tbm_pkg::ROW_SUM_W-1:0] out_sum_ff;
   tbm_pkg::tag_type              out_tag_ff;

   // handshake
   logic out_free, s2_move, s1_move, accept, mask_acc, load_acc;

   // derived configuration and per-beat control
   logic [CW-1:0]   cols, wpr_raw, wpr;
   logic [RCW-1:0]  rows;
   logic            word_last, row_last;
   logic [NL-1:0]   lane_en;
   logic [RXW-1:0]  row_wide;
   tbm_pkg::tag_type acc_tag;

   // load path
   logic [XW-1:0]   wr_col;
   logic [AW-1:0]   wr_row;
   logic            wr_ok;

   // word sum
   logic signed [tbm_pkg::WSUM_W-1:0] term [NL];
   logic signed [tbm_pkg::WSUM_W-1:0] t16 [16];
   logic signed [tbm_pkg::WSUM_W-1:0] t8 [8];
   logic signed [tbm_pkg::WSUM_W-1:0] t4 [4];
   logic signed [tbm_pkg::WSUM_W-1:0] t2 [2];
   logic signed [tbm_pkg::WSUM_W-1:0] wsum;
   logic signed [ACC_W-1:0]           acc_sum;
   logic signed [tbm_pkg::ROW_SUM_W-1:0] sat_sum;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s2_move   = !s2_valid_ff || !s2_tag_ff.row_end || out_free;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign accept    = req_valid && s1_move;
   assign mask_acc  = accept && (req_cmd == tbm_pkg::CMD_MASK);
   assign load_acc  = accept && (req_cmd == tbm_pkg::CMD_LOAD);

   assign csr_ready = 1'b1;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (csr_valid) begin
         case (csr_index)
            tbm_pkg::CSR_COL_COUNT: col_count_in = csr_wdata;
            tbm_pkg::CSR_ROW_COUNT: row_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cols = (CW'(col_count_ff) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(col_count_ff);
      wpr_raw = (cols + CW'(tbm_pkg::WORD_BITS - 1)) >> tbm_pkg::LANE_W;
      wpr = (wpr_raw == '0) ? CW'(1) : wpr_raw;
      if (row_count_ff == '0) begin
         rows = RCW'(1);
      end else if (RCW'(row_count_ff) > RCW'(MAX_ROWS)) begin
         rows = RCW'(MAX_ROWS);
      end else begin
         rows = RCW'(row_count_ff);
      end
      word_last = (CW'(word_ff) + CW'(1)) >= wpr;
      row_last  = (RCW'(row_ff) + RCW'(1)) >= rows;
      for (int b = 0; b < NL; b++) begin
         lane_en[b] = ((CW'(word_ff) << tbm_pkg::LANE_W) + CW'(b)) < cols;
      end
      row_wide = RXW'(row_ff);
      acc_tag.row_end   = word_last;
      acc_tag.last_row  = row_last;
      acc_tag.row_index = row_wide[tbm_pkg::ROW_INDEX_W-1:0];
   end

   always_comb begin
      word_in = word_ff;
      row_in  = row_ff;
      if (mask_acc) begin
         if (word_last) begin
            word_in = '0;
            row_in  = row_last ? '0 : row_ff + RW'(1);
         end else begin
            word_in = word_ff + AW'(1);
         end
      end
   end

   assign wr_col = XW'(req_act_index);
   assign wr_row = AW'(wr_col >> tbm_pkg::LANE_W);
   assign wr_ok  = wr_col < XW'(MAX_COLS);

   // one bank per lane, same row address on every bank for a mask beat
   for (genvar g = 0; g < NL; g++) begin : g_bank
      logic [tbm_pkg::ACT_W-1:0] bank_mem [WORDS];

      always_ff @(posedge clock) begin
         if (load_acc && wr_ok && (req_act_index[tbm_pkg::LANE_W-1:0] == tbm_pkg::LANE_W'(g)))
         begin
            bank_mem[wr_row] <= req_act_value;
         end
         if (mask_acc) begin
            s1_act_ff[g] <= bank_mem[word_ff];
         end
      end
   end

   // ternary lanes and adder tree
   always_comb begin
      for (int b = 0; b < NL; b++) begin
         if (s1_pos_ff[b] && !s1_neg_ff[b]) begin
            term[b] = tbm_pkg::WSUM_W'(signed'(s1_act_ff[b]));
         end else if (s1_neg_ff[b] && !s1_pos_ff[b]) begin
            term[b] = -tbm_pkg::WSUM_W'(signed'(s1_act_ff[b]));
         end else begin
            term[b] = '0;
         end
      end
      for (int i = 0; i < 16; i++) t16[i] = term[2*i] + term[2*i+1];
      for (int i = 0; i < 8; i++)  t8[i]  = t16[2*i] + t16[2*i+1];
      for (int i = 0; i < 4; i++)  t4[i]  = t8[2*i] + t8[2*i+1];
      for (int i = 0; i < 2; i++)  t2[i]  = t4[2*i] + t4[2*i+1];
      wsum = t2[0] + t2[1];
   end

   always_comb begin
      acc_sum = acc_ff + ACC_W'(s2_wsum_ff);
      if (acc_sum > ACC_W'(tbm_pkg::SUM_MAX)) begin
         sat_sum = tbm_pkg::ROW_SUM_W'(tbm_pkg::SUM_MAX);
      end else if (acc_sum < ACC_W'(tbm_pkg::SUM_MIN)) begin
         sat_sum = tbm_pkg::ROW_SUM_W'(tbm_pkg::SUM_MIN);
      end else begin
         sat_sum = acc_sum[tbm_pkg::ROW_SUM_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in  = s1_move ? mask_acc : s1_valid_ff;
      s2_valid_in  = s2_move ? s1_valid_ff : s2_valid_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (s2_valid_ff && s2_move) begin
         if (s2_tag_ff.row_end) begin
            acc_in       = '0;
            out_valid_in = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= tbm_pkg::COL_COUNT_RESET;
         row_count_ff <= tbm_pkg::ROW_COUNT_RESET;
         word_ff      <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         word_ff      <= word_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mask_acc) begin
         s1_pos_ff <= req_pos_word & lane_en;
         s1_neg_ff <= req_neg_word & lane_en;
         s1_tag_ff <= acc_tag;
      end
      if (s2_move && s1_valid_ff) begin
         s2_wsum_ff <= wsum;
         s2_tag_ff  <= s1_tag_ff;
      end
      if (s2_valid_ff && s2_move && s2_tag_ff.row_end) begin
         out_sum_ff <= sat_sum;
         out_tag_ff <= s2_tag_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_sum   = out_sum_ff;
   assign rsp_row_index = out_tag_ff.row_index;
   assign rsp_last_row  = out_tag_ff.last_row;

endmodule

// ===== dv/ternary_bitmask_matvec_test.sv =====
// ternary_bitmask_matvec_test: self-checking bench for the ternary bitmask matvec block.
// Keeps its own mirror of activations, row accumulator and counters to predict row results.
// Depends on tbm_pkg and ternary_bitmask_matvec.

module ternary_bitmask_matvec_test;

   localparam int MAX_COLS      = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 90;

   typedef struct packed {
      logic signed [tbm_pkg::ROW_SUM_W-1:0] row_sum;
      logic [tbm_pkg::ROW_INDEX_W-1:0]      row_index;
      logic                                 last_row;
   } row_result_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_cmd = 1'b0;
   logic [tbm_pkg::ACT_INDEX_W-1:0]      req_act_index = '0;
   logic signed [tbm_pkg::ACT_W-1:0]     req_act_value = '0;
   logic [tbm_pkg::WORD_BITS-1:0]        req_pos_word = '0;
   logic [tbm_pkg::WORD_BITS-1:0]        req_neg_word = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [tbm_pkg::ROW_SUM_W-1:0] rsp_row_sum;
   logic [tbm_pkg::ROW_INDEX_W-1:0]      rsp_row_index;
   logic                                 rsp_last_row;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic                                 csr_index = tbm_pkg::CSR_COL_COUNT;
   logic [tbm_pkg::CFG_W-1:0]            csr_wdata = '0;

   // mirror of the block
   logic signed [tbm_pkg::ACT_W-1:0] act_mirror [MAX_COLS];
   int                               sum_acc = 0;
   int unsigned                      word_pos = 0;
   int unsigned                      row_pos = 0;
   logic [tbm_pkg::CFG_W-1:0]        cfg_cols = tbm_pkg::COL_COUNT_RESET;
   logic [tbm_pkg::CFG_W-1:0]        cfg_rows = tbm_pkg::ROW_COUNT_RESET;

   row_result_type pending_rows [$];
   row_result_type want_row;
   int             fail_count = 0;
   int unsigned    cycle_count = 0;
   bit             gaps_on = 1'b1;
   bit             start_hold = 1'b0;
   int             hold_left = 0;

   ternary_bitmask_matvec #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit accumulate_beat(input tbm_pkg::cmd_type cmd,
         input logic [tbm_pkg::ACT_INDEX_W-1:0] idx,
         input logic signed [tbm_pkg::ACT_W-1:0] val,
         input logic [tbm_pkg::WORD_BITS-1:0] pos, input logic [tbm_pkg::WORD_BITS-1:0] neg,
         output row_result_type row);
      int unsigned cols, words, rows, base, b;
      int          total;
      row = '0;
      if (cmd == tbm_pkg::CMD_LOAD) begin
         if (idx < MAX_COLS) act_mirror[idx] = val;
         return 1'b0;
      end
      cols  = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
      words = (cols + tbm_pkg::WORD_BITS - 1) / tbm_pkg::WORD_BITS;
      if (words == 0) words = 1;
      base = word_pos * tbm_pkg::WORD_BITS;
      for (b = 0; b < tbm_pkg::WORD_BITS; b++) begin
         if (base + b >= cols) break;
         if (pos[b]) sum_acc += act_mirror[base + b];
         if (neg[b]) sum_acc -= act_mirror[base + b];
      end
      if (word_pos + 1 < words) begin
         word_pos++;
         return 1'b0;
      end
      rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows);
      total = sum_acc;
      if (total > tbm_pkg::SUM_MAX) total = tbm_pkg::SUM_MAX;
      if (total < tbm_pkg::SUM_MIN) total = tbm_pkg::SUM_MIN;
      row.row_sum   = total[tbm_pkg::ROW_SUM_W-1:0];
      row.row_index = row_pos[tbm_pkg::ROW_INDEX_W-1:0];
      row.last_row  = (row_pos + 1 >= rows);
      sum_acc  = 0;
      word_pos = 0;
      row_pos  = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      return 1'b1;
   endfunction

   function automatic logic [tbm_pkg::WORD_BITS-1:0] rand_mask();
      case ($urandom_range(5))
         0: return '1;
         1: return '0;
         2: return $urandom & $urandom & $urandom;
         default: return $urandom;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
         input logic signed [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // result side: random stall, plus a long hold on request
   always @(negedge clock) begin
      if (start_hold) begin
         start_hold = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= gaps_on && ($urandom_range(99) < 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rows.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected row beat, expected none actual sum %0d index %0d",
                     $time, rsp_row_sum, rsp_row_index);
         end else begin
            want_row = pending_rows.pop_front();
            check_field("row_sum", want_row.row_sum, rsp_row_sum);
            check_field("row_index", want_row.row_index, rsp_row_index);
            check_field("last_row", want_row.last_row, rsp_last_row);
         end
      end
   end

   task automatic send_beat(input tbm_pkg::cmd_type cmd,
         input logic [tbm_pkg::ACT_INDEX_W-1:0] idx,
         input logic signed [tbm_pkg::ACT_W-1:0] val,
         input logic [tbm_pkg::WORD_BITS-1:0] pos, input logic [tbm_pkg::WORD_BITS-1:0] neg);
      row_result_type row;
      @(negedge clock);
      if (gaps_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_act_index <= idx;
      req_act_value <= val;
      req_pos_word  <= pos;
      req_neg_word  <= neg;
      do @(posedge clock); while (req_stall);
      if (accumulate_beat(cmd, idx, val, pos, neg, row)) pending_rows.push_back(row);
   endtask

   task automatic send_load(input logic [tbm_pkg::ACT_INDEX_W-1:0] idx,
         input logic signed [tbm_pkg::ACT_W-1:0] val);
      send_beat(tbm_pkg::CMD_LOAD, idx, val, $urandom, $urandom);
   endtask

   task automatic send_mask(input logic [tbm_pkg::WORD_BITS-1:0] pos,
         input logic [tbm_pkg::WORD_BITS-1:0] neg);
      send_beat(tbm_pkg::CMD_MASK, tbm_pkg::ACT_INDEX_W'($urandom),
                tbm_pkg::ACT_W'($urandom), pos, neg);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_rows();
      stop_sending();
      while (pending_rows.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [tbm_pkg::CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == tbm_pkg::CSR_COL_COUNT) cfg_cols = data;
      else cfg_rows = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [tbm_pkg::CFG_W-1:0] cols,
         input logic [tbm_pkg::CFG_W-1:0] rows);
      drain_rows();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(tbm_pkg::CSR_COL_COUNT, cols);
      write_csr(tbm_pkg::CSR_ROW_COUNT, rows);
   endtask

   task automatic test_fill_activations();
      for (int i = 0; i < MAX_COLS; i++)
         send_load(tbm_pkg::ACT_INDEX_W'(i), tbm_pkg::ACT_W'($urandom));
   endtask

   task automatic test_extremes();
      send_load(10'd0, 8'sh7f);
      send_load(10'd1, 8'sh80);
      send_load(10'd30, 8'sh7f);
      send_load(10'd31, 8'sh80);
      configure(11'd32, 11'd3);
      send_mask('1, '0);
      send_mask('0, '1);
      send_mask('1, '1);
      send_mask(32'h0000_0001, 32'h0000_0002);
      send_mask(32'h8000_0000, 32'h4000_0000);
   endtask

   task automatic test_cutoff_and_zero_sizes();
      configure(11'd37, 11'd2);
      send_mask('1, '0);
      send_mask('1, '0);
      send_mask('0, '1);
      send_mask('0, '1);
      configure(11'd0, 11'd0);
      send_mask('1, '0);
      send_mask($urandom, $urandom);
      configure(11'd1, 11'd1);
      send_mask('1, 32'h0000_0002);
   endtask

   task automatic test_mid_row_change();
      configure(11'd96, 11'd8);
      send_mask('1, '0);
      configure(11'd32, 11'd8);
      send_mask('1, '0);
      repeat (4) send_mask(rand_mask(), rand_mask());
      configure(11'd32, 11'd3);
      send_mask(rand_mask(), rand_mask());
      send_mask(rand_mask(), rand_mask());
   endtask

   task automatic test_output_hold();
      configure(11'd32, 11'd16);
      gaps_on = 1'b0;
      start_hold = 1'b1;
      repeat (48) send_mask(rand_mask(), rand_mask());
      gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (12) send_mask(rand_mask(), rand_mask());
      drain_rows();
      repeat (12) send_mask(rand_mask(), rand_mask());
   endtask

   task automatic test_random_traffic();
      logic [tbm_pkg::CFG_W-1:0] cols, rows;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               cols = 11'd1024;
               rows = 11'd3;
            end
            1: begin
               cols = '1;
               rows = '1;
            end
            2: begin
               cols = '0;
               rows = 11'd5;
            end
            3: begin
               cols = 11'd1025;
               rows = '0;
            end
            default: begin
               cols = ($urandom_range(9) < 7) ? tbm_pkg::CFG_W'($urandom_range(1, 96))
                                              : tbm_pkg::CFG_W'($urandom_range(0, 2047));
               rows = ($urandom_range(9) < 6) ? tbm_pkg::CFG_W'($urandom_range(1, 8))
                                              : tbm_pkg::CFG_W'($urandom_range(0, 2047));
            end
         endcase
         configure(cols, rows);
         gaps_on = (phase != 9);
         repeat (28) begin
            if ($urandom_range(99) < 12)
               send_load(tbm_pkg::ACT_INDEX_W'($urandom), tbm_pkg::ACT_W'($urandom));
            else send_mask(rand_mask(), rand_mask());
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d row beats outstanding", $time, pending_rows.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_fill_activations();
      test_extremes();
      test_cutoff_and_zero_sizes();
      test_mid_row_change();
      test_output_hold();
      test_sender_pause();
      test_random_traffic();
      drain_rows();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== ternary_bitmask_matvec.f =====
design/tbm_pkg.sv
design/ternary_bitmask_matvec.sv
dv/ternary_bitmask_matvec_test.sv
